// ===== src/gap_constrained_occurrence_counter_defines.svh =====
// Assertion macros for the occurrence counter checker
`ifndef GAP_CONSTRAINED_OCCURRENCE_COUNTER_DEFINES_SVH
`define GAP_CONSTRAINED_OCCURRENCE_COUNTER_DEFINES_SVH
// implication checked on every clock while out of reset
`define GCOC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GCOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/gcoc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcoc_pkg
// Types and codes shared by the occurrence counter and its checker.
// ----------------------------------------------------------------------------
package gcoc_pkg;
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] REG_MIN_GAP = 2'd0;
	localparam logic [1:0] REG_MAX_GAP = 2'd1;
	localparam logic [1:0] REG_PAT_LEN = 2'd2;

	localparam int CFG_W = 12;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] symbol;
		logic [5:0] pattern_index;
	} in_item_t;

	typedef struct packed {
		logic [12:0] sequence_count;
		logic [31:0] total_count;
		logic        overflow;
	} out_item_t;
endpackage

// ===== src/gap_constrained_occurrence_counter.sv =====
// ----------------------------------------------------------------------------
// gap_constrained_occurrence_counter
// Counts non-overlapping gap-constrained occurrences of a loaded pattern.
// ----------------------------------------------------------------------------
// Load, append and clear items are taken back to back. An end-of-sequence
// item first marks every pattern level unused, one level per cycle, then
// runs a depth-first search over the sequence memory: each root is read
// (ROOT), then compared (RCMP); each examined position is read (SCAN), then
// compared (SCMP); a step down a level passes LVLRD and LVL; a backtrack
// step passes POP, POPRD, LVLRD and LVL, so the time grows with sequence
// length times the gap window in the worst case. The result is registered
// in the done state and waits there while the previous result is still not
// taken; input is held off for the whole count. Search state (position tried
// and last-used position per level) sits in small synchronous memories
// indexed by pattern level.
module gap_constrained_occurrence_counter #(
	parameter int SEQ_DEPTH   = 4096,
	parameter int MAX_PATTERN = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  gcoc_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output gcoc_pkg::out_item_t   out_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [gcoc_pkg::CFG_W-1:0] cfg_wdata
);
	import gcoc_pkg::*;

	localparam int AW = $clog2(SEQ_DEPTH);
	localparam int PW = (MAX_PATTERN > 2) ? $clog2(MAX_PATTERN) : 1;
	localparam int LW = AW + 1;
	localparam int PLW = $clog2(MAX_PATTERN + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ROOT  = 4'd1;
	localparam logic [3:0] ST_RCMP  = 4'd2;
	localparam logic [3:0] ST_LVL   = 4'd3;
	localparam logic [3:0] ST_LVLRD = 4'd4;
	localparam logic [3:0] ST_SCAN  = 4'd5;
	localparam logic [3:0] ST_SCMP  = 4'd6;
	localparam logic [3:0] ST_POP   = 4'd7;
	localparam logic [3:0] ST_POPRD = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;
	localparam logic [3:0] ST_CLR   = 4'd10;

	logic [7:0] seq_mem [SEQ_DEPTH];
	logic [7:0] pat_mem [MAX_PATTERN];
	// per level: position tried (stack), last used position, used mark
	logic [AW-1:0] pos_mem [MAX_PATTERN];
	logic [AW-1:0] used_mem [MAX_PATTERN];
	logic          live_mem [MAX_PATTERN];

	logic [11:0]    min_gap_q, max_gap_q;
	logic [6:0]     pat_len_q;
	logic [LW-1:0]  seq_len_q;
	logic [31:0]    total_q;
	logic           ovf_q;
	logic [3:0]     state_q;
	logic [LW-1:0]  root_q, j_q, hi_q, parent_q;
	logic [PLW-1:0] lvl_q, eff_q;
	logic [12:0]    cnt_q;
	logic [7:0]     seq_rd_q, pat_rd_q;
	logic [AW-1:0]  pos_rd_q, used_rd_q;
	logic           live_rd_q;
	logic           out_valid_q;
	out_item_t      out_q;

	logic           in_fire;
	logic           out_load;
	logic [LW-1:0]  seq_addr;
	logic [PW-1:0]  lvl_addr;
	logic           lvl_we;
	logic [AW-1:0]  lvl_wpos;
	logic [LW+12:0] lo_w, hi_w;
	logic [LW-1:0]  lo_c;
	logic [32:0]    sum_w;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// memory address selection
	always_comb begin
		seq_addr = j_q;
		if (state_q == ST_ROOT)
			seq_addr = root_q;
		lvl_addr = lvl_q[PW-1:0];
		if (state_q == ST_POP)
			lvl_addr = PW'(lvl_q - PLW'(2));
		if (state_q == ST_ROOT)
			lvl_addr = '0;
	end

	always_ff @(posedge clk) begin
		seq_rd_q <= seq_mem[seq_addr[AW-1:0]];
		pat_rd_q <= pat_mem[lvl_addr];
		pos_rd_q <= pos_mem[lvl_addr];
		used_rd_q <= used_mem[lvl_addr];
		live_rd_q <= live_mem[lvl_addr];
		if (in_fire && in_data.command == CMD_APPEND && seq_len_q < LW'(SEQ_DEPTH))
			seq_mem[seq_len_q[AW-1:0]] <= in_data.symbol;
		if (in_fire && in_data.command == CMD_LOAD
			&& 32'(in_data.pattern_index) < MAX_PATTERN)
			pat_mem[PW'(in_data.pattern_index)] <= in_data.symbol;
		if (lvl_we) begin
			pos_mem[lvl_q[PW-1:0]] <= lvl_wpos;
			used_mem[lvl_q[PW-1:0]] <= lvl_wpos;
		end
		if (lvl_we || state_q == ST_CLR)
			live_mem[lvl_q[PW-1:0]] <= lvl_we;
	end

	// search window of the current level
	always_comb begin
		lo_w = (LW+13)'(parent_q) + (LW+13)'(min_gap_q) + 1'b1;
		hi_w = (LW+13)'(parent_q) + (LW+13)'(max_gap_q) + 1'b1;
		if (live_rd_q && (LW+13)'(used_rd_q) >= lo_w)
			lo_w = (LW+13)'(used_rd_q) + 1'b1;
		lo_c = (lo_w > (LW+13)'(seq_len_q)) ? seq_len_q : lo_w[LW-1:0];
		lvl_we = (state_q == ST_SCMP) && (seq_rd_q == pat_rd_q);
		lvl_wpos = j_q[AW-1:0];
		sum_w = {1'b0, total_q} + 33'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q   <= '0;
			max_gap_q   <= '0;
			pat_len_q   <= 7'd1;
			seq_len_q   <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			root_q <= '0; j_q <= '0; hi_q <= '0; parent_q <= '0;
			lvl_q <= '0; eff_q <= '0; cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_GAP: min_gap_q <= cfg_wdata;
					REG_MAX_GAP: max_gap_q <= cfg_wdata;
					REG_PAT_LEN: pat_len_q <= cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (in_data.command)
							CMD_APPEND: begin
								if (seq_len_q < LW'(SEQ_DEPTH))
									seq_len_q <= seq_len_q + 1'b1;
								else
									ovf_q <= 1'b1;
							end
							CMD_CLEAR: total_q <= '0;
							CMD_END: begin
								cnt_q <= '0;
								root_q <= '0;
								lvl_q <= '0;
								if (pat_len_q == 7'd0)
									eff_q <= PLW'(1);
								else if (32'(pat_len_q) > MAX_PATTERN)
									eff_q <= PLW'(MAX_PATTERN);
								else
									eff_q <= PLW'(pat_len_q);
								state_q <= ST_CLR;
							end
							default: ;
						endcase
					end
				end
				ST_CLR: begin
					// mark levels unused, one per cycle
					if (lvl_q + PLW'(1) >= eff_q)
						state_q <= ST_ROOT;
					else
						lvl_q <= lvl_q + PLW'(1);
				end
				ST_ROOT: begin
					if ((LW+1)'(root_q) + (LW+1)'(eff_q) > (LW+1)'(seq_len_q))
						state_q <= ST_DONE;
					else
						state_q <= ST_RCMP;
				end
				ST_RCMP: begin
					if (seq_rd_q != pat_rd_q) begin
						root_q <= root_q + 1'b1;
						state_q <= ST_ROOT;
					end else if (eff_q == PLW'(1)) begin
						if (cnt_q != 13'h1fff) cnt_q <= cnt_q + 1'b1;
						root_q <= root_q + 1'b1;
						state_q <= ST_ROOT;
					end else begin
						parent_q <= root_q;
						lvl_q <= PLW'(1);
						state_q <= ST_LVLRD;
					end
				end
				ST_LVLRD: state_q <= ST_LVL;
				ST_LVL: begin
					j_q <= lo_c;
					hi_q <= (hi_w >= (LW+13)'(seq_len_q)) ? seq_len_q - 1'b1
						: hi_w[LW-1:0];
					if (lo_w >= (LW+13)'(seq_len_q)
						|| lo_w > hi_w)
						state_q <= ST_POP;
					else
						state_q <= ST_SCAN;
				end
				ST_SCAN: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (lvl_we) begin
						if (lvl_q + PLW'(1) == eff_q) begin
							if (cnt_q != 13'h1fff) cnt_q <= cnt_q + 1'b1;
							root_q <= root_q + 1'b1;
							state_q <= ST_ROOT;
						end else begin
							parent_q <= j_q;
							lvl_q <= lvl_q + PLW'(1);
							state_q <= ST_LVLRD;
						end
					end else if (j_q >= hi_q) begin
						state_q <= ST_POP;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_POP: begin
					// backtrack: resume scan of previous level after its position
					if (lvl_q == PLW'(1)) begin
						root_q <= root_q + 1'b1;
						state_q <= ST_ROOT;
					end else begin
						lvl_q <= lvl_q - PLW'(1);
						state_q <= ST_POPRD;
					end
				end
				ST_POPRD: begin
					// parent of the resumed level
					if (lvl_q == PLW'(1))
						parent_q <= root_q;
					else
						parent_q <= LW'(pos_rd_q);
					state_q <= ST_LVLRD;
				end
				ST_DONE: begin
					if (out_load) begin
						total_q <= sum_w[32] ? 32'hffff_ffff : sum_w[31:0];
						out_q.sequence_count <= cnt_q;
						out_q.total_count <= sum_w[32] ? 32'hffff_ffff : sum_w[31:0];
						out_q.overflow <= ovf_q;
						seq_len_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== src/gcoc_checker.sv =====
// ----------------------------------------------------------------------------
// gcoc_checker
// Port-level checks on the occurrence counter.
// ----------------------------------------------------------------------------
`include "gap_constrained_occurrence_counter_defines.svh"
module gcoc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input gcoc_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input gcoc_pkg::out_item_t out_data
);
	import gcoc_pkg::*;

	`GCOC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
	`GCOC_ASSERT_IMPL(a_out_known, clk, arst_n, out_valid, !$isunknown(out_data), "result fields unknown")
	`GCOC_ASSERT_NEXT(a_end_busy, clk, arst_n, in_valid && in_ready && in_data.command == CMD_END, !in_ready, "end of sequence did not start a count")
	`GCOC_ASSERT_IMPL(a_cnt_le_total, clk, arst_n, out_valid, {19'd0, out_data.sequence_count} <= out_data.total_count, "total below sequence count")
endmodule

bind gap_constrained_occurrence_counter gcoc_checker u_gcoc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);
